// ===== design/svm_minibatch_sgd_trainer_core_macros.svh =====
// Assertion macros shared by the SVM trainer RTL
`ifndef SVM_MINIBATCH_SGD_TRAINER_CORE_MACROS_SVH
`define SVM_MINIBATCH_SGD_TRAINER_CORE_MACROS_SVH

// same-cycle implication
`define SVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/svmsgd_pkg.sv =====
// Package: constants, codes and types of the SVM SGD trainer
package svmsgd_pkg;
    localparam int MAX_FEATURES = 64;
    localparam int IDX_W        = $clog2(MAX_FEATURES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int W_W          = 32;
    localparam int G_W          = 40;
    localparam int X_W          = 16;
    localparam int DOT_W        = 64;
    localparam int LOSS_W       = 48;
    localparam int TL_W         = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [15:0] LEARN_RATE_RST = 16'd655;
    localparam logic [15:0] BATCH_LEN_RST  = 16'd100;
    localparam logic [6:0]  FEAT_CNT_RST   = 7'd54;

    typedef enum logic {
        REQ_FEATURE = 1'b0,
        REQ_FLUSH   = 1'b1
    } t_req;

    typedef enum logic {
        KIND_TUPLE  = 1'b0,
        KIND_WEIGHT = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE = 2'd0,
        CFG_BATCH_LEN  = 2'd1,
        CFG_FEAT_CNT   = 2'd2
    } t_cfg_idx;
endpackage

// ===== design/svmsgd_if.sv =====
// Channel interfaces: input word, result word, configuration write
interface svmsgd_in_if;
    import svmsgd_pkg::*;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic signed [15:0] feature_value;
    logic signed [1:0]  label_val;
    logic              first_pass;
    modport source (output valid, req_type, feature_value, label_val, first_pass,
                    input ready);
    modport sink   (input valid, req_type, feature_value, label_val, first_pass,
                    output ready);
endinterface

interface svmsgd_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [31:0]        row_loss;
    logic               model_updated;
    logic [5:0]         weight_index;
    logic signed [31:0] weight_value;
    logic [47:0]        loss_accum;
    logic [31:0]        rows_seen;
    logic               run_last;
    modport source (output valid, result_kind, row_loss, model_updated, weight_index,
                    weight_value, loss_accum, rows_seen, run_last, input ready);
    modport sink   (input valid, result_kind, row_loss, model_updated, weight_index,
                    weight_value, loss_accum, rows_seen, run_last, output ready);
endinterface

interface svmsgd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/svm_minibatch_sgd_trainer_core.sv =====
// Linear SVM mini-batch SGD trainer, sequenced over one shared datapath
//
// i_in carries one word per feature element (req_type 0) or an end-of-pass
// flush (req_type 1). o_out returns one tuple report after the last feature
// of a tuple and one weight readout per feature in use after a flush.
// i_cfg writes learn_rate, batch_len, feature_count; it is always ready; the user
// must write it only while the block is idle; the block itself does not enforce this.
// Steps per word, ready low meanwhile:
//   feature element, not last : weight read, multiply, accumulate
//   last feature              : the same, then a gradient walk over the features
//                               in use when y*w.x < 1, a 64-weight update when the
//                               batch closes, then the report waits for o_out.ready
//   flush                     : the update, then readouts that each wait for ready
// One read address for the memories and one product register set these steps.
// Reset clears all weights and gradients through valid bits, and losses and counters
// directly. A stalled receiver holds the result word and the block.
module svm_minibatch_sgd_trainer_core
    import svmsgd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    svmsgd_in_if.sink     i_in,
    svmsgd_out_if.source  o_out,
    svmsgd_cfg_if.sink    i_cfg
);
`include "svm_minibatch_sgd_trainer_core_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_F_RD, S_F_MUL, S_F_ACC, S_LAST, S_G_RD, S_G_WR, S_BATCH,
        S_U_RD, S_U_MUL, S_U_WR, S_R_RD, S_R_LD, S_OUT
    } t_state;

    t_state r_state;

    logic [15:0] r_learn_rate, r_batch_len;
    logic [6:0]  r_feat_cnt;

    logic [W_W-1:0]   r_wmem [MAX_FEATURES];
    logic [G_W-1:0]   r_gmem [MAX_FEATURES];
    logic [X_W-1:0]   r_fmem [MAX_FEATURES];
    logic [MAX_FEATURES-1:0] r_wvld, r_gvld;

    logic [W_W-1:0] r_w_rd;
    logic [G_W-1:0] r_g_rd;
    logic [X_W-1:0] r_f_rd;
    logic           r_wv_rd, r_gv_rd;

    logic [IDX_W-1:0]        r_i, r_lim;
    logic signed [X_W-1:0]   r_x;
    logic signed [1:0]       r_y;
    logic                    r_first;
    logic                    r_flush;
    logic signed [56:0]      r_prod;
    logic signed [DOT_W-1:0] r_dot;
    logic [CNT_W-1:0]        r_fpos;
    logic [15:0]             r_bpos;
    logic [LOSS_W-1:0]       r_bloss, r_ltot;
    logic [31:0]             r_rows;
    logic [TL_W-1:0]         r_tl;

    logic                    r_o_kind, r_o_upd, r_o_last;
    logic [TL_W-1:0]         r_o_tl;
    logic [IDX_W-1:0]        r_o_idx;
    logic [W_W-1:0]          r_o_w;

    logic [CNT_W-1:0] nf;
    logic [16:0]      blen;
    logic signed [W_W-1:0] w_eff;
    logic signed [G_W-1:0] g_eff;
    logic signed [DOT_W-1:0] m;
    logic signed [DOT_W:0]   diff;
    logic [TL_W-1:0]         tl;
    logic signed [G_W:0]     g_sum;
    logic signed [G_W-1:0]   g_sat;
    logic signed [52:0]      w_inc;
    logic signed [53:0]      w_sum;
    logic signed [W_W-1:0]   w_sat;
    logic [LOSS_W:0]         bl_sum, lt_sum;
    logic [IDX_W-1:0]        pos_in;
    logic                    in_acc, out_acc;

    always_comb begin
        if (r_feat_cnt == '0) begin
            nf = CNT_W'(1);
        end else if (r_feat_cnt > 7'(MAX_FEATURES)) begin
            nf = CNT_W'(MAX_FEATURES);
        end else begin
            nf = CNT_W'(r_feat_cnt);
        end
        blen  = (r_batch_len == '0) ? 17'd1 : {1'b0, r_batch_len};
        w_eff = r_wv_rd ? $signed(r_w_rd) : '0;
        g_eff = r_gv_rd ? $signed(r_g_rd) : '0;

        if (r_y == 2'sd1) begin
            m = r_dot;
        end else if (r_y == 2'sd0) begin
            m = '0;
        end else begin
            m = -r_dot;
        end
        diff = (DOT_W+1)'(64'sd1 <<< 36) - (DOT_W+1)'(m);
        if (diff <= 0) begin
            tl = '0;
        end else if ((diff >>> 20) > (DOT_W+1)'(33'h0FFFFFFFF)) begin
            tl = '1;
        end else begin
            tl = TL_W'(diff >>> 20);
        end

        g_sum = (G_W+1)'(g_eff) + (G_W+1)'(r_y) * (G_W+1)'($signed(r_f_rd));
        if (g_sum > (G_W+1)'(41'sh07FFFFFFFFF)) begin
            g_sat = {1'b0, {(G_W-1){1'b1}}};
        end else if (g_sum < -(G_W+1)'(41'sh08000000000)) begin
            g_sat = {1'b1, {(G_W-1){1'b0}}};
        end else begin
            g_sat = G_W'(g_sum);
        end

        w_inc = 53'(r_prod >>> 4);
        w_sum = 54'(w_eff) + 54'(w_inc);
        if (w_sum > 54'sd2147483647) begin
            w_sat = 32'sh7FFFFFFF;
        end else if (w_sum < -54'sd2147483648) begin
            w_sat = 32'sh80000000;
        end else begin
            w_sat = W_W'(w_sum);
        end

        bl_sum = {1'b0, r_bloss} + (LOSS_W+1)'(r_tl);
        lt_sum = {1'b0, r_ltot} + {1'b0, r_bloss};
        pos_in = r_fpos[IDX_W-1:0];
        in_acc  = i_in.valid && i_in.ready;
        out_acc = o_out.valid && o_out.ready;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = (r_state == S_OUT);
    assign o_out.result_kind   = r_o_kind;
    assign o_out.row_loss      = r_o_tl;
    assign o_out.model_updated = r_o_upd;
    assign o_out.weight_index  = r_o_idx;
    assign o_out.weight_value  = r_o_w;
    assign o_out.loss_accum    = r_ltot;
    assign o_out.rows_seen     = r_rows;
    assign o_out.run_last      = r_o_last;

    // memories: one read address, registered data
    always_ff @(posedge i_clk) begin
        r_w_rd <= r_wmem[r_i];
        r_g_rd <= r_gmem[r_i];
        r_f_rd <= r_fmem[r_i];
        if (in_acc && i_in.req_type == REQ_FEATURE) begin
            r_fmem[pos_in] <= i_in.feature_value;
        end
        if (r_state == S_G_WR) begin
            r_gmem[r_i] <= g_sat;
        end else if (r_state == S_U_WR) begin
            r_gmem[r_i] <= '0;
        end
        if (r_state == S_U_WR) begin
            r_wmem[r_i] <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_learn_rate <= LEARN_RATE_RST;
            r_batch_len  <= BATCH_LEN_RST;
            r_feat_cnt   <= FEAT_CNT_RST;
            r_wvld       <= '0;
            r_gvld       <= '0;
            r_wv_rd      <= 1'b0;
            r_gv_rd      <= 1'b0;
            r_i          <= '0;
            r_dot        <= '0;
            r_fpos       <= '0;
            r_bpos       <= '0;
            r_bloss      <= '0;
            r_ltot       <= '0;
            r_rows       <= '0;
            r_flush      <= 1'b0;
        end else begin
            r_wv_rd <= r_wvld[r_i];
            r_gv_rd <= r_gvld[r_i];
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_LEARN_RATE: r_learn_rate <= i_cfg.data;
                    CFG_BATCH_LEN:  r_batch_len  <= i_cfg.data;
                    CFG_FEAT_CNT:   r_feat_cnt   <= i_cfg.data[6:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.req_type == REQ_FLUSH) begin
                            r_flush <= 1'b1;
                            r_bpos  <= '0;
                            r_fpos  <= '0;
                            r_dot   <= '0;
                            r_i     <= '0;
                            r_state <= S_U_RD;
                        end else begin
                            r_flush <= 1'b0;
                            r_x     <= i_in.feature_value;
                            r_y     <= (i_in.label_val == 2'sd1) ? 2'sd1 :
                                       (i_in.label_val == 2'sd0) ? 2'sd0 : -2'sd1;
                            r_first <= i_in.first_pass;
                            r_i     <= pos_in;
                            r_state <= S_F_RD;
                        end
                    end
                end
                S_F_RD: r_state <= S_F_MUL;
                S_F_MUL: begin
                    r_prod  <= 57'(w_eff) * 57'(r_x);
                    r_state <= S_F_ACC;
                end
                S_F_ACC: begin
                    r_dot <= r_dot + DOT_W'(r_prod);
                    if ({1'b0, r_i} + CNT_W'(1) < nf) begin
                        r_fpos  <= {1'b0, r_i} + CNT_W'(1);
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_tl      <= tl;
                    r_lim     <= r_i;
                    r_i       <= '0;
                    if (r_first && r_rows != '1) begin
                        r_rows <= r_rows + 32'd1;
                    end
                    r_state   <= (m < (64'sd1 <<< 36)) ? S_G_RD : S_BATCH;
                end
                S_G_RD: r_state <= S_G_WR;
                S_G_WR: begin
                    r_gvld[r_i] <= 1'b1;
                    if (r_i == r_lim) begin
                        r_state <= S_BATCH;
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_G_RD;
                    end
                end
                S_BATCH: begin
                    r_bloss <= bl_sum[LOSS_W] ? '1 : bl_sum[LOSS_W-1:0];
                    r_dot   <= '0;
                    r_fpos  <= '0;
                    r_i     <= '0;
                    if ({1'b0, r_bpos} + 17'd1 >= blen) begin
                        r_bpos  <= '0;
                        r_state <= S_U_RD;
                    end else begin
                        r_bpos   <= r_bpos + 16'd1;
                        r_o_kind <= KIND_TUPLE;
                        r_o_tl   <= r_tl;
                        r_o_upd  <= 1'b0;
                        r_o_idx  <= '0;
                        r_o_w    <= '0;
                        r_o_last <= 1'b0;
                        r_state  <= S_OUT;
                    end
                end
                S_U_RD: r_state <= S_U_MUL;
                S_U_MUL: begin
                    r_prod  <= $signed({1'b0, r_learn_rate}) * g_eff;
                    r_state <= S_U_WR;
                end
                S_U_WR: begin
                    r_wvld[r_i] <= 1'b1;
                    r_gvld[r_i] <= 1'b1;
                    if (r_i == IDX_W'(MAX_FEATURES - 1)) begin
                        r_ltot  <= lt_sum[LOSS_W] ? '1 : lt_sum[LOSS_W-1:0];
                        r_bloss <= '0;
                        r_i     <= '0;
                        if (r_flush) begin
                            r_state <= S_R_RD;
                        end else begin
                            r_o_kind <= KIND_TUPLE;
                            r_o_tl   <= r_tl;
                            r_o_upd  <= 1'b1;
                            r_o_idx  <= '0;
                            r_o_w    <= '0;
                            r_o_last <= 1'b0;
                            r_state  <= S_OUT;
                        end
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_U_RD;
                    end
                end
                S_R_RD: r_state <= S_R_LD;
                S_R_LD: begin
                    r_o_kind <= KIND_WEIGHT;
                    r_o_tl   <= '0;
                    r_o_upd  <= 1'b0;
                    r_o_idx  <= r_i;
                    r_o_w    <= w_eff;
                    r_o_last <= ({1'b0, r_i} + CNT_W'(1) == nf);
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (out_acc) begin
                        if (r_flush && !r_o_last) begin
                            r_i     <= r_i + IDX_W'(1);
                            r_state <= S_R_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SVM_ASSERT_IMP(a_last_idx, i_clk, i_rst_n,
        o_out.valid && o_out.result_kind == KIND_WEIGHT && o_out.run_last,
        {1'b0, o_out.weight_index} + CNT_W'(1) == nf, "last readout index mismatch")
    `SVM_ASSERT_IMP(a_upd_bpos, i_clk, i_rst_n,
        o_out.valid && o_out.result_kind == KIND_TUPLE && o_out.model_updated,
        r_bpos == '0, "batch position not restarted after update")
    `SVM_ASSERT_NXT(a_busy, i_clk, i_rst_n,
        i_in.valid && i_in.ready, !i_in.ready, "accepted a word while busy")
    `SVM_ASSERT_IMP(a_readout_zero, i_clk, i_rst_n,
        o_out.valid && o_out.result_kind == KIND_WEIGHT,
        o_out.row_loss == '0 && !o_out.model_updated, "readout carries tuple fields")

endmodule
